// ----- rtl/swcb_pkg.sv -----
`timescale 1ns / 1ps
package swcb_pkg;

  localparam int MAX_BINS = 64;
  localparam int CHANNELS = 512;

  localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NBIN_W = $clog2(MAX_BINS + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = BIN_W + CH_W;
  localparam int DEPTH  = MAX_BINS * (2 ** CH_W);

  localparam int LEN_W   = 20;
  localparam int BINS_W  = 7;
  localparam int TIME_W  = 32;
  localparam int CHF_W   = 9;
  localparam int KIND_W  = 2;
  localparam int NB_W    = 34;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 22;
  localparam int CURB_W  = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(300);
  localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(11);

  localparam logic [KIND_W-1:0] KIND_SPIKE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIME  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic CFG_BIN_LENGTH  = 1'b0;
  localparam logic CFG_BINS_IN_USE = 1'b1;

endpackage

// ----- rtl/swcb_ram.sv -----
`timescale 1ns / 1ps
module swcb_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/swcb_div.sv -----
`timescale 1ns / 1ps
module swcb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [swcb_pkg::NB_W-1:0]  num_i,
  input  logic [swcb_pkg::LEN_W-1:0] den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [swcb_pkg::NB_W-1:0]  quo_o,
  output logic [swcb_pkg::LEN_W-1:0] rem_o
);
  import swcb_pkg::*;

  localparam int CW = $clog2(NB_W);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [NB_W-1:0]  quo_q, quo_d;
  logic [LEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [LEN_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[NB_W-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NB_W-2:0], fits};
      rem_d = fits ? LEN_W'(trial - {1'b0, den_q}) : LEN_W'(trial);
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NB_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < den_q) else $error("divider remainder too large");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i) |=> (busy_q || done_q)) else $error("divider lost its work");
`endif

endmodule

// ----- rtl/sliding_window_channel_event_binner_unit.sv -----
`timescale 1ns / 1ps
// Channel event binner over a ring of time bins. Counts live in one 32768 x 16
// single-port RAM addressed by {bin, channel}; every division on times goes
// through one shared serial divider. After reset and after every configuration
// write the RAM is swept to zero with s_axis_tready low. Per item: a read sums
// the channel over the bins in use; a spike inside the current boundary takes
// one division and a read-modify-write; an item that moves the ring takes two
// divisions, clears from one bin up to the whole ring, then lets a spike do its
// read-modify-write; other time items and kind 3 go straight to the result. One
// result word leaves per accepted word unless a configuration write cuts it
// short; the next word can enter while a result still waits on m_axis_tready.
module sliding_window_channel_event_binner_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [swcb_pkg::LEN_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // event_time[31:0], channel[40:32], zero pad
  input  logic [swcb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  logic [swcb_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // window_count[21:0], current_bin[27:22], zero pad
  output logic [swcb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // dropped[0]
  output logic                               m_axis_tuser
);
  import swcb_pkg::*;

  localparam logic [3:0] S_CLRALL = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DIV1   = 4'd2;
  localparam logic [3:0] S_DIV2   = 4'd3;
  localparam logic [3:0] S_DIV3   = 4'd4;
  localparam logic [3:0] S_CLRB   = 4'd5;
  localparam logic [3:0] S_RMWR   = 4'd6;
  localparam logic [3:0] S_RMWW   = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;
  localparam logic [3:0] S_RDL    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [BINS_W-1:0] bins_q, bins_d;
  logic [NB_W-1:0]   nb_q, nb_d;
  logic [BIN_W-1:0]  newest_q, newest_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [TIME_W-1:0] t_q, t_d;
  logic [CHF_W-1:0]  ch_q, ch_d;
  logic [BIN_W-1:0]  clr_bin_q, clr_bin_d, tgt_q, tgt_d, rd_bin_q, rd_bin_d;
  logic [NBIN_W-1:0] clr_left_q, clr_left_d;
  logic [CH_W-1:0]   ch_ctr_q, ch_ctr_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              drop_q, drop_d;
  logic              ov_q, ov_d;
  logic [SUM_W-1:0]  o_sum_q, o_sum_d;
  logic              o_drop_q, o_drop_d;
  logic [CURB_W-1:0] o_bin_q, o_bin_d;

  logic [LEN_W-1:0]  len_eff, cfg_len_eff;
  logic [NBIN_W-1:0] n_eff;
  logic [NB_W-1:0]   t34;
  logic              ch_ok;
  logic              div_start, div_busy, div_done;
  logic [NB_W-1:0]   div_num, div_quo;
  logic [LEN_W-1:0]  div_den, div_rem;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [CNT_W-1:0]  ram_wdata, ram_rdata;
  logic              accept;
  logic [BIN_W-1:0]  nw_fix;
  logic [NB_W-1:0]   n34;
  logic [NBIN_W:0]   nsum;
  logic [NBIN_W-1:0] dn, nw_ext, clr_next;

  assign len_eff     = (len_q == '0) ? LEN_W'(1) : len_q;
  assign cfg_len_eff = (cfg_data_i == '0) ? LEN_W'(1) : cfg_data_i;
  always_comb begin
    if (bins_q == '0) begin
      n_eff = NBIN_W'(1);
    end else if (bins_q > BINS_W'(MAX_BINS)) begin
      n_eff = NBIN_W'(MAX_BINS);
    end else begin
      n_eff = NBIN_W'(bins_q);
    end
  end
  assign t34    = NB_W'(t_q);
  assign n34    = NB_W'(n_eff);
  assign ch_ok  = 13'(ch_q) < 13'(CHANNELS);
  assign nw_ext = NBIN_W'(newest_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    bins_d     = bins_q;
    nb_d       = nb_q;
    newest_d   = newest_q;
    sweep_d    = sweep_q;
    kind_d     = kind_q;
    t_d        = t_q;
    ch_d       = ch_q;
    clr_bin_d  = clr_bin_q;
    clr_left_d = clr_left_q;
    ch_ctr_d   = ch_ctr_q;
    tgt_d      = tgt_q;
    rd_bin_d   = rd_bin_q;
    sum_d      = sum_q;
    drop_d     = drop_q;
    ov_d       = ov_q;
    o_sum_d    = o_sum_q;
    o_drop_d   = o_drop_q;
    o_bin_d    = o_bin_q;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = len_eff;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = {tgt_q, ch_q[CH_W-1:0]};
    ram_wdata  = '0;
    nw_fix     = (nw_ext >= n_eff) ? '0 : newest_q;
    nsum       = '0;
    dn         = '0;
    clr_next   = '0;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_CLRALL: begin
        ram_we   = 1'b1;
        ram_addr = sweep_q;
        sweep_d  = sweep_q + ADDR_W'(1);
        if (sweep_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_d   = s_axis_tuser;
          t_d      = s_axis_tdata[TIME_W-1:0];
          ch_d     = s_axis_tdata[TIME_W +: CHF_W];
          newest_d = nw_fix;
          sum_d    = '0;
          drop_d   = 1'b0;
          rd_bin_d = '0;
          state_d  = S_OUT;
          if ((s_axis_tuser == KIND_SPIKE || s_axis_tuser == KIND_TIME) &&
              NB_W'(s_axis_tdata[TIME_W-1:0]) > nb_q) begin
            div_start = 1'b1;
            div_num   = NB_W'(s_axis_tdata[TIME_W-1:0]) - nb_q - NB_W'(1);
            state_d   = S_DIV1;
          end else if (s_axis_tuser == KIND_SPIKE) begin
            div_start = 1'b1;
            div_num   = nb_q - NB_W'(s_axis_tdata[TIME_W-1:0]);
            state_d   = S_DIV3;
          end else if (s_axis_tuser == KIND_READ &&
                       13'(s_axis_tdata[TIME_W +: CHF_W]) < 13'(CHANNELS)) begin
            state_d = S_RD;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          nb_d    = t34 + NB_W'(len_eff) - NB_W'(1) - NB_W'(div_rem);
          clr_next = (nw_ext + NBIN_W'(1) == n_eff) ? '0 : nw_ext + NBIN_W'(1);
          if (div_quo + NB_W'(1) >= n34) begin
            clr_left_d = n_eff;
            clr_bin_d  = '0;
          end else begin
            clr_left_d = NBIN_W'(div_quo + NB_W'(1));
            clr_bin_d  = BIN_W'(clr_next);
          end
          div_start = 1'b1;
          div_num   = div_quo + NB_W'(1);
          div_den   = LEN_W'(n_eff);
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        div_den = LEN_W'(n_eff);
        if (div_done) begin
          nsum     = (NBIN_W + 1)'(nw_ext) + (NBIN_W + 1)'(div_rem);
          newest_d = (nsum >= (NBIN_W + 1)'(n_eff)) ?
                     BIN_W'(nsum - (NBIN_W + 1)'(n_eff)) : BIN_W'(nsum);
          ch_ctr_d = '0;
          state_d  = S_CLRB;
        end
      end
      S_CLRB: begin
        // zero one channel of the bin being retired
        ram_we   = 1'b1;
        ram_addr = {clr_bin_q, ch_ctr_q};
        ch_ctr_d = ch_ctr_q + CH_W'(1);
        if (ch_ctr_q == CH_W'(CHANNELS - 1)) begin
          ch_ctr_d   = '0;
          clr_left_d = clr_left_q - NBIN_W'(1);
          clr_bin_d  = (NBIN_W'(clr_bin_q) + NBIN_W'(1) == n_eff) ?
                       '0 : clr_bin_q + BIN_W'(1);
          if (clr_left_q == NBIN_W'(1)) begin
            // after an advance the spike always lands in the newest bin
            tgt_d   = newest_q;
            state_d = (kind_q == KIND_SPIKE && ch_ok) ? S_RMWR : S_OUT;
          end
        end
      end
      S_DIV3: begin
        if (div_done) begin
          if (div_quo >= n34) begin
            drop_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            dn    = NBIN_W'(div_quo);
            tgt_d = (nw_ext >= dn) ? BIN_W'(nw_ext - dn) : BIN_W'(nw_ext + n_eff - dn);
            state_d = ch_ok ? S_RMWR : S_OUT;
          end
        end
      end
      S_RMWR: begin
        ram_re  = 1'b1;
        state_d = S_RMWW;
      end
      S_RMWW: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);
        state_d   = S_OUT;
      end
      S_RD: begin
        ram_re   = 1'b1;
        ram_addr = {rd_bin_q, ch_q[CH_W-1:0]};
        if (rd_bin_q != '0) begin
          sum_d = sum_q + SUM_W'(ram_rdata);
        end
        rd_bin_d = rd_bin_q + BIN_W'(1);
        if (NBIN_W'(rd_bin_q) + NBIN_W'(1) == n_eff) begin
          state_d = S_RDL;
        end
      end
      S_RDL: begin
        sum_d   = sum_q + SUM_W'(ram_rdata);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d     = 1'b1;
          o_sum_d  = sum_q;
          o_drop_d = drop_q;
          o_bin_d  = CURB_W'(newest_q);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BIN_LENGTH) begin
        len_d = cfg_data_i;
        nb_d  = NB_W'(cfg_len_eff);
      end else begin
        bins_d = cfg_data_i[BINS_W-1:0];
        nb_d   = NB_W'(len_eff);
      end
      newest_d = '0;
      sweep_d  = '0;
      state_d  = S_CLRALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLRALL;
      len_q      <= LEN_RESET;
      bins_q     <= BINS_RESET;
      nb_q       <= NB_W'(LEN_RESET);
      newest_q   <= '0;
      sweep_q    <= '0;
      ov_q       <= 1'b0;
      clr_left_q <= '0;
      ch_ctr_q   <= '0;
      rd_bin_q   <= '0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      bins_q     <= bins_d;
      nb_q       <= nb_d;
      newest_q   <= newest_d;
      sweep_q    <= sweep_d;
      ov_q       <= ov_d;
      clr_left_q <= clr_left_d;
      ch_ctr_q   <= ch_ctr_d;
      rd_bin_q   <= rd_bin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    t_q       <= t_d;
    ch_q      <= ch_d;
    clr_bin_q <= clr_bin_d;
    tgt_q     <= tgt_d;
    sum_q     <= sum_d;
    drop_q    <= drop_d;
    o_sum_q   <= o_sum_d;
    o_drop_q  <= o_drop_d;
    o_bin_q   <= o_bin_d;
  end

  swcb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  swcb_ram #(
    .Width (CNT_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - SUM_W - CURB_W)'(0), o_bin_q, o_sum_q};
  assign m_axis_tuser  = o_drop_q;

`ifndef SYNTH
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_RDL) |-> !ram_we) else $error("write during window sum");
  a_newest_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_OUT) |-> (nw_ext < n_eff))
    else $error("newest bin outside ring");
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == S_OUT) else $error("result without item");
`endif

endmodule
